### hw/rtl/bol_pkg.sv
// Shared types and constants for the bounded ordered list.
package bol_pkg;

   localparam int DEPTH_DEFAULT = 8;
   localparam int POS_W         = 8;
   localparam int WORD_W        = 32;
   localparam int OUT_W         = 4;

   localparam logic signed [OUT_W-1:0] FOUND_NONE = -4'sd1;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_DELETE = 2'd1,
      ACT_SEARCH = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FIND
   } state_type;

   // Broadcast to every cell of the row.
   typedef struct packed {
      logic               insert_en;
      logic               delete_en;
      logic [POS_W-1:0]   pos;
      logic [POS_W-1:0]   count;
      logic [WORD_W-1:0]  value;
   } cell_cmd_type;

endpackage

### hw/rtl/bol_cell.sv
// One slot of the list: holds a word, shifts with its neighbours, flags a match.
module bol_cell #(
   parameter int INDEX = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bol_pkg::cell_cmd_type       cmd,
   input  logic [bol_pkg::WORD_W-1:0]  prev_word,
   input  logic [bol_pkg::WORD_W-1:0]  next_word,
   output logic [bol_pkg::WORD_W-1:0]  word,
   output logic                        match
);

   localparam logic [bol_pkg::POS_W-1:0] MY_POS = bol_pkg::POS_W'(INDEX);

   logic [bol_pkg::WORD_W-1:0] word_ff, word_in;
   logic                       match_ff, match_in;

   always_comb begin
      word_in = word_ff;
      if (cmd.insert_en) begin
         if (MY_POS == cmd.pos) begin
            word_in = cmd.value;
         end else if (MY_POS > cmd.pos) begin
            word_in = prev_word;
         end
      end else if (cmd.delete_en) begin
         if (MY_POS >= cmd.pos) begin
            word_in = next_word;
         end
      end
      match_in = (word_ff == cmd.value) && (MY_POS < cmd.count);
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign word  = word_ff;
   assign match = match_ff;

endmodule

### hw/rtl/bounded_ordered_list.sv
// Top level of the bounded ordered list: control, cell row and result register.
//
//   channel | direction | handshake          | fields
//   req     | in        | req_valid/req_stall | action, position, item_value
//   rsp     | out       | rsp_valid/rsp_stall | ok, removed_value, found_position,
//           |           |                     | list_length
//
// Each item passes through capture, cell update and match, then first-match encode.
// A new item is taken only after the previous one has been loaded into the result register.
// Reset clears the length and control; slot contents are not cleared.
// A stalled result holds the engine in its encode step until the beat is taken.
module bounded_ordered_list #(
   parameter int DEPTH = bol_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_action,
   input  logic [bol_pkg::POS_W-1:0]           req_position,
   input  logic signed [bol_pkg::WORD_W-1:0]   req_item_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_ok,
   output logic signed [bol_pkg::WORD_W-1:0]   rsp_removed_value,
   output logic signed [bol_pkg::OUT_W-1:0]    rsp_found_position,
   output logic [bol_pkg::OUT_W-1:0]           rsp_list_length
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   bol_pkg::state_type state_ff, state_in;

   bol_pkg::action_type              act_ff;
   logic [bol_pkg::POS_W-1:0]        pos_ff;
   logic [bol_pkg::WORD_W-1:0]       val_ff;
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic                             ok_ff, ok_in;
   logic [bol_pkg::WORD_W-1:0]       removed_ff, removed_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_ok_ff;
   logic [bol_pkg::WORD_W-1:0]       rsp_removed_ff;
   logic [bol_pkg::OUT_W-1:0]        rsp_found_ff;
   logic [bol_pkg::OUT_W-1:0]        rsp_len_ff;

   logic                             accept;
   logic                             rsp_load;
   logic                             ins_ok, del_ok;
   logic [bol_pkg::POS_W-1:0]        count_pos;
   bol_pkg::cell_cmd_type            cmd;
   logic [bol_pkg::WORD_W-1:0]       words [DEPTH];
   logic [DEPTH-1:0]                 match;
   logic                             hit;
   logic [IDX_W-1:0]                 hit_idx;
   logic [IDX_W+bol_pkg::OUT_W-1:0]  idx_ext;
   logic [CNT_W+bol_pkg::OUT_W-1:0]  len_ext;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != bol_pkg::ST_IDLE);
   assign count_pos = bol_pkg::POS_W'(count_ff);

   assign ins_ok = (act_ff == bol_pkg::ACT_INSERT) && (count_ff < CNT_W'(DEPTH))
                   && (pos_ff <= count_pos);
   assign del_ok = (act_ff == bol_pkg::ACT_DELETE) && (pos_ff < count_pos);

   always_comb begin
      cmd           = '0;
      cmd.pos       = pos_ff;
      cmd.count     = count_pos;
      cmd.value     = val_ff;
      cmd.insert_en = (state_ff == bol_pkg::ST_EXEC) && ins_ok;
      cmd.delete_en = (state_ff == bol_pkg::ST_EXEC) && del_ok;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [bol_pkg::WORD_W-1:0] prev_w, next_w;
      if (i == 0) begin : g_first
         assign prev_w = '0;
      end else begin : g_mid
         assign prev_w = words[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign next_w = '0;
      end else begin : g_inner
         assign next_w = words[i+1];
      end
      bol_cell #(.INDEX(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .prev_word (prev_w),
         .next_word (next_w),
         .word      (words[i]),
         .match     (match[i])
      );
   end

   // first set match bit
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit     = 1'b1;
            hit_idx = IDX_W'(i);
         end
      end
   end

   assign idx_ext = {{bol_pkg::OUT_W{1'b0}}, hit_idx};
   assign len_ext = {{bol_pkg::OUT_W{1'b0}}, count_ff};

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ok_in        = ok_ff;
      removed_in   = removed_ff;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         bol_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = bol_pkg::ST_EXEC;
            end
         end
         bol_pkg::ST_EXEC: begin
            ok_in      = ins_ok || del_ok;
            removed_in = del_ok ? words[pos_ff[IDX_W-1:0]] : '0;
            if (ins_ok) begin
               count_in = count_ff + CNT_W'(1);
            end else if (del_ok) begin
               count_in = count_ff - CNT_W'(1);
            end
            state_in = bol_pkg::ST_FIND;
         end
         bol_pkg::ST_FIND: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = bol_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bol_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bol_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff <= bol_pkg::action_type'(req_action);
         pos_ff <= req_position;
         val_ff <= req_item_value;
      end
      ok_ff      <= ok_in;
      removed_ff <= removed_in;
      if (rsp_load) begin
         if (act_ff == bol_pkg::ACT_SEARCH) begin
            rsp_ok_ff    <= hit;
            rsp_found_ff <= hit ? idx_ext[bol_pkg::OUT_W-1:0] : bol_pkg::FOUND_NONE;
         end else begin
            rsp_ok_ff    <= ok_ff;
            rsp_found_ff <= bol_pkg::FOUND_NONE;
         end
         rsp_removed_ff <= removed_ff;
         rsp_len_ff     <= len_ext[bol_pkg::OUT_W-1:0];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_removed_value  = rsp_removed_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_list_length    = rsp_len_ff;

endmodule

### hw/rtl/bol_checker.sv
// Port-level checks for the bounded ordered list, bound to the top level.
module bol_checker #(
   parameter int DEPTH = bol_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic                                rsp_ok,
   input  logic signed [bol_pkg::WORD_W-1:0]   rsp_removed_value,
   input  logic signed [bol_pkg::OUT_W-1:0]    rsp_found_position
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request beat taken while previous still in work");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_found_position != bol_pkg::FOUND_NONE) |-> rsp_ok)
      else $error("match position given without ok");

   a_removed_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_removed_value != '0) |-> rsp_ok)
      else $error("removed word given without ok");

endmodule

bind bounded_ordered_list bol_checker #(.DEPTH(DEPTH)) u_bol_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_ok             (rsp_ok),
   .rsp_removed_value  (rsp_removed_value),
   .rsp_found_position (rsp_found_position)
);
